// File: hw/rtl/cbm_pkg.sv
// shared types and constants for the cartridge bank mapper with irq counter
package cbm_pkg;

    // action codes carried by a request
    typedef enum logic [2:0] {
        ACT_CPU_WRITE  = 3'd0,
        ACT_CPU_READ   = 3'd1,
        ACT_TICK       = 3'd2,
        ACT_PPU_LOOKUP = 3'd3,
        ACT_CPU_LOOKUP = 3'd4
    } action_t;

    // memory kinds reported by a lookup
    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_PRG_ROM = 3'd1,
        KIND_PRG_RAM = 3'd2,
        KIND_CHR_ROM = 3'd3,
        KIND_CIRAM   = 3'd4
    } kind_t;

    // board variants
    localparam logic [1:0] VAR_M19    = 2'd0;
    localparam logic [1:0] VAR_M210_1 = 2'd1;
    localparam logic [1:0] VAR_M210_2 = 2'd2;
    localparam logic [1:0] VAR_ALIAS  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_VARIANT     = 2'd0;
    localparam logic [1:0] REG_LAST_PRG    = 2'd1;
    localparam logic [1:0] REG_HARD_MIRROR = 2'd2;

    // nametable mirroring modes
    localparam logic [1:0] MIR_SINGLE0    = 2'd0;
    localparam logic [1:0] MIR_VERTICAL   = 2'd1;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd2;
    localparam logic [1:0] MIR_SINGLE1    = 2'd3;

    // cpu write decode on address bits 15:11
    localparam logic [4:0] PAGE_IRQ_LO  = 5'b01010;
    localparam logic [4:0] PAGE_IRQ_HI  = 5'b01011;
    localparam logic [4:0] PAGE_NT_LO   = 5'b11000;
    localparam logic [4:0] PAGE_NT_HI   = 5'b11011;
    localparam logic [4:0] PAGE_PRG0    = 5'b11100;
    localparam logic [4:0] PAGE_PRG1    = 5'b11101;
    localparam logic [4:0] PAGE_PRG2    = 5'b11110;

    localparam logic [15:0] IRQ_MATCH  = 16'h7FFE;
    localparam logic [7:0]  CIRAM_EDGE = 8'hE0;

    // bank state seen by the address lookup
    typedef struct packed {
        logic [1:0]      variant;
        logic [5:0]      last_prg_bank;
        logic            hard_mirroring;
        logic [7:0][7:0] pattern_banks;
        logic [3:0][7:0] nametable_regs;
        logic [2:0][5:0] prg_banks;
        logic [1:0]      pattern_mode;
        logic [1:0]      mirror_mode;
    } bank_state_t;

    // lookup answer
    typedef struct packed {
        logic        hit;
        kind_t       kind;
        logic [7:0]  bank;
        logic [12:0] offset;
    } map_t;

endpackage

// File: hw/rtl/cbm_lookup.sv
// cpu and ppu address lookup against the bank registers
module cbm_lookup (
    input  cbm_pkg::bank_state_t st,
    input  logic                 ppu_sel,
    input  logic [15:0]          address,
    output cbm_pkg::map_t        map
);

    cbm_pkg::map_t cpu_map;
    cbm_pkg::map_t ppu_map;
    logic [2:0]    pat_slot;
    logic [7:0]    pat_bank;
    logic          pat_mode_bit;
    logic [1:0]    nt_slot;
    logic [7:0]    nt_reg;
    logic          page;

    // cpu side: prg rom windows and prg ram
    always_comb
    begin
        cpu_map = '0;
        if (address[15])
        begin
            cpu_map.hit    = 1'b1;
            cpu_map.kind   = cbm_pkg::KIND_PRG_ROM;
            cpu_map.offset = address[12:0];
            unique case (address[14:13])
                2'd0:    cpu_map.bank = {2'b00, st.prg_banks[0]};
                2'd1:    cpu_map.bank = {2'b00, st.prg_banks[1]};
                2'd2:    cpu_map.bank = {2'b00, st.prg_banks[2]};
                default: cpu_map.bank = {2'b00, st.last_prg_bank};
            endcase
        end
        else if (address[14:13] == 2'b11)
        begin
            if (st.variant == cbm_pkg::VAR_M19)
            begin
                cpu_map.hit    = 1'b1;
                cpu_map.kind   = cbm_pkg::KIND_PRG_RAM;
                cpu_map.offset = address[12:0];
            end
            else if (st.variant == cbm_pkg::VAR_M210_1)
            begin
                // 2 KB mirrored across the window
                cpu_map.hit    = 1'b1;
                cpu_map.kind   = cbm_pkg::KIND_PRG_RAM;
                cpu_map.offset = {2'b00, address[10:0]};
            end
        end
    end

    // ppu side: pattern slots and nametables
    assign pat_slot     = address[12:10];
    assign pat_bank     = st.pattern_banks[pat_slot];
    assign pat_mode_bit = st.pattern_mode[pat_slot[2]];
    assign nt_slot      = address[11:10];
    assign nt_reg       = st.nametable_regs[nt_slot];

    // ciram page for boards with fixed or selectable mirroring
    always_comb
    begin
        if (st.variant == cbm_pkg::VAR_M210_1)
        begin
            page = st.hard_mirroring ? nt_slot[1] : nt_slot[0];
        end
        else
        begin
            unique case (st.mirror_mode)
                cbm_pkg::MIR_SINGLE0:    page = 1'b0;
                cbm_pkg::MIR_VERTICAL:   page = nt_slot[0];
                cbm_pkg::MIR_HORIZONTAL: page = nt_slot[1];
                default:                 page = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        ppu_map        = '0;
        ppu_map.hit    = 1'b1;
        ppu_map.offset = {3'b000, address[9:0]};
        if (!address[13])
        begin
            if (st.variant == cbm_pkg::VAR_M19 && pat_bank >= cbm_pkg::CIRAM_EDGE
                && !pat_mode_bit)
            begin
                ppu_map.kind = cbm_pkg::KIND_CIRAM;
                ppu_map.bank = {7'd0, pat_bank[0]};
            end
            else
            begin
                ppu_map.kind = cbm_pkg::KIND_CHR_ROM;
                ppu_map.bank = pat_bank;
            end
        end
        else if (st.variant == cbm_pkg::VAR_M19)
        begin
            if (nt_reg >= cbm_pkg::CIRAM_EDGE)
            begin
                ppu_map.kind = cbm_pkg::KIND_CIRAM;
                ppu_map.bank = {7'd0, nt_reg[0]};
            end
            else
            begin
                ppu_map.kind = cbm_pkg::KIND_CHR_ROM;
                ppu_map.bank = nt_reg;
            end
        end
        else
        begin
            ppu_map.kind = cbm_pkg::KIND_CIRAM;
            ppu_map.bank = {7'd0, page};
        end
    end

    assign map = ppu_sel ? ppu_map : cpu_map;

endmodule

// File: hw/rtl/cartridge_bank_mapper_irq_core.sv
// top level of the cartridge bank mapper with irq counter
//
//  port group     | handshake                    | payload
//  ---------------+------------------------------+-------------------------------------
//  request in     | item_valid / item_ready      | action, address, data
//  result out     | result_valid / result_ready  | read_data, read_hit, irq_line,
//                 |                              | map_kind, map_bank, map_offset
//  configuration  | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// one request per cycle sustained while result_ready stays high; an accepted request
// sits in the input register, then decode and state update load the result register
// a stalled result holds the result register and the input register takes one more
// request; after that item_ready drops until result_ready returns; reset clears bank,
// pattern mode and counter state; mirror mode comes up vertical and ram enable set
module cartridge_bank_mapper_irq_core (
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [2:0]  action,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    // result channel
    output logic        result_valid,
    input  logic        result_ready,
    output logic [7:0]  read_data,
    output logic        read_hit,
    output logic        irq_line,
    output logic [2:0]  map_kind,
    output logic [7:0]  map_bank,
    output logic [12:0] map_offset,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [1:0] variant_reg;
    logic [5:0] last_prg_bank_reg;
    logic       hard_mirroring_reg;

    // mapper state
    logic [7:0][7:0] pattern_banks_reg,  pattern_banks_next;
    logic [3:0][7:0] nametable_regs_reg, nametable_regs_next;
    logic [2:0][5:0] prg_banks_reg,      prg_banks_next;
    logic [1:0]      pattern_mode_reg,   pattern_mode_next;
    logic            ram_on_reg,         ram_on_next;
    logic [15:0]     irq_count_reg,      irq_count_next;
    logic            irq_on_reg,         irq_on_next;
    logic            irq_ack_reg,        irq_ack_next;
    logic            irq_level_reg,      irq_level_next;
    logic [1:0]      mirror_mode_reg,    mirror_mode_next;

    // input register
    logic        s1_valid_reg;
    logic [2:0]  s1_action_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_data_reg;

    // result register
    logic        out_valid_reg;
    logic [7:0]  read_data_reg,  read_data_next;
    logic        read_hit_reg,   read_hit_next;
    logic        irq_line_reg;
    logic [2:0]  map_kind_reg;
    logic [7:0]  map_bank_reg;
    logic [12:0] map_offset_reg;
    cbm_pkg::map_t res_map_next;

    logic                 s1_fire;
    logic                 cfg_write;
    logic [1:0]           eff_variant;
    logic [15:0]          count_inc;
    cbm_pkg::bank_state_t bank_state;
    cbm_pkg::map_t        lookup_map;
    cbm_pkg::action_t     act;

    // handshake
    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || s1_fire;
    assign result_valid = out_valid_reg;
    assign pready       = 1'b1;
    assign cfg_write    = psel && penable && pwrite;

    // variant code 3 behaves as submapper 2
    assign eff_variant = (variant_reg == cbm_pkg::VAR_ALIAS) ? cbm_pkg::VAR_M210_2 : variant_reg;
    assign act         = cbm_pkg::action_t'(s1_action_reg);
    assign count_inc   = irq_count_reg + 16'd1;

    assign bank_state.variant        = eff_variant;
    assign bank_state.last_prg_bank  = last_prg_bank_reg;
    assign bank_state.hard_mirroring = hard_mirroring_reg;
    assign bank_state.pattern_banks  = pattern_banks_reg;
    assign bank_state.nametable_regs = nametable_regs_reg;
    assign bank_state.prg_banks      = prg_banks_reg;
    assign bank_state.pattern_mode   = pattern_mode_reg;
    assign bank_state.mirror_mode    = mirror_mode_reg;

    cbm_lookup u_lookup (
        .st      (bank_state),
        .ppu_sel (act == cbm_pkg::ACT_PPU_LOOKUP),
        .address (s1_address_reg),
        .map     (lookup_map)
    );

    // configuration readback
    always_comb
    begin
        unique case (paddr[3:2])
            cbm_pkg::REG_VARIANT:     prdata = {30'd0, variant_reg};
            cbm_pkg::REG_LAST_PRG:    prdata = {26'd0, last_prg_bank_reg};
            cbm_pkg::REG_HARD_MIRROR: prdata = {31'd0, hard_mirroring_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // request decode and state update
    always_comb
    begin
        pattern_banks_next  = pattern_banks_reg;
        nametable_regs_next = nametable_regs_reg;
        prg_banks_next      = prg_banks_reg;
        pattern_mode_next   = pattern_mode_reg;
        ram_on_next         = ram_on_reg;
        irq_count_next      = irq_count_reg;
        irq_on_next         = irq_on_reg;
        irq_ack_next        = irq_ack_reg;
        irq_level_next      = irq_level_reg;
        mirror_mode_next    = mirror_mode_reg;
        read_data_next      = 8'd0;
        read_hit_next       = 1'b0;
        res_map_next        = '0;

        // only a leaving request, or a variant write for ram enable, touches the state
        if (s1_fire)
        begin
            unique case (act)
                cbm_pkg::ACT_CPU_WRITE:
                begin
                    if (eff_variant != cbm_pkg::VAR_M19 && !s1_address_reg[15])
                    begin
                        // low writes ignored on the 210 boards
                    end
                    else if (s1_address_reg[15:13] == 3'b011)
                    begin
                        // ram write reports its location when enabled
                        if (ram_on_reg)
                        begin
                            res_map_next = lookup_map;
                        end
                    end
                    else
                    begin
                        priority if (s1_address_reg[15:11] == cbm_pkg::PAGE_IRQ_LO)
                        begin
                            irq_count_next = {irq_count_reg[15:8], s1_data_reg};
                            irq_ack_next   = 1'b1;
                        end
                        else if (s1_address_reg[15:11] == cbm_pkg::PAGE_IRQ_HI)
                        begin
                            irq_on_next    = s1_data_reg[7];
                            irq_count_next = {1'b0, s1_data_reg[6:0], irq_count_reg[7:0]};
                            irq_ack_next   = 1'b1;
                        end
                        else if (s1_address_reg[15:14] == 2'b10)
                        begin
                            pattern_banks_next[s1_address_reg[13:11]] = s1_data_reg;
                        end
                        else if (s1_address_reg[15:11] >= cbm_pkg::PAGE_NT_LO
                                 && s1_address_reg[15:11] <= cbm_pkg::PAGE_NT_HI)
                        begin
                            if (eff_variant == cbm_pkg::VAR_M210_1
                                && s1_address_reg[12:11] == 2'd0)
                            begin
                                ram_on_next = s1_data_reg[0];
                            end
                            if (eff_variant == cbm_pkg::VAR_M19)
                            begin
                                nametable_regs_next[s1_address_reg[12:11]] = s1_data_reg;
                            end
                        end
                        else if (s1_address_reg[15:11] == cbm_pkg::PAGE_PRG0)
                        begin
                            if (eff_variant == cbm_pkg::VAR_M210_2)
                            begin
                                mirror_mode_next = s1_data_reg[7:6];
                            end
                            prg_banks_next[0] = s1_data_reg[5:0];
                        end
                        else if (s1_address_reg[15:11] == cbm_pkg::PAGE_PRG1)
                        begin
                            prg_banks_next[1] = s1_data_reg[5:0];
                            if (eff_variant == cbm_pkg::VAR_M19)
                            begin
                                pattern_mode_next = s1_data_reg[7:6];
                            end
                        end
                        else if (s1_address_reg[15:11] == cbm_pkg::PAGE_PRG2)
                        begin
                            prg_banks_next[2] = s1_data_reg[5:0];
                        end
                    end
                end

                cbm_pkg::ACT_CPU_READ:
                begin
                    if (s1_address_reg[15] || s1_address_reg[14:13] == 2'b11)
                    begin
                        read_hit_next = lookup_map.hit;
                        res_map_next  = lookup_map;
                    end
                    else if (s1_address_reg[15:11] == cbm_pkg::PAGE_IRQ_LO)
                    begin
                        read_data_next = irq_count_reg[7:0];
                        read_hit_next  = 1'b1;
                    end
                    else if (s1_address_reg[15:11] == cbm_pkg::PAGE_IRQ_HI)
                    begin
                        read_data_next = irq_count_reg[15:8];
                        read_hit_next  = 1'b1;
                    end
                end

                cbm_pkg::ACT_TICK:
                begin
                    // pending acknowledge drops the line first
                    if (irq_ack_reg)
                    begin
                        irq_level_next = 1'b0;
                        irq_ack_next   = 1'b0;
                    end
                    if (irq_on_reg)
                    begin
                        irq_count_next = count_inc;
                        if (count_inc == cbm_pkg::IRQ_MATCH)
                        begin
                            irq_level_next = 1'b1;
                            irq_on_next    = 1'b0;
                        end
                    end
                end

                cbm_pkg::ACT_PPU_LOOKUP,
                cbm_pkg::ACT_CPU_LOOKUP:
                begin
                    res_map_next = lookup_map;
                end

                default:
                begin
                end
            endcase
        end

        // a miss carries no location
        if (!res_map_next.hit)
        begin
            res_map_next = '0;
        end

        // the user must land configuration writes only while idle; the block has no check
        if (cfg_write && paddr[3:2] == cbm_pkg::REG_VARIANT)
        begin
            ram_on_next = (pwdata[1:0] == cbm_pkg::VAR_M19);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg        <= cbm_pkg::VAR_M19;
            last_prg_bank_reg  <= 6'h3F;
            hard_mirroring_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[3:2] == cbm_pkg::REG_VARIANT)
            begin
                variant_reg <= pwdata[1:0];
            end
            if (paddr[3:2] == cbm_pkg::REG_LAST_PRG)
            begin
                last_prg_bank_reg <= pwdata[5:0];
            end
            if (paddr[3:2] == cbm_pkg::REG_HARD_MIRROR)
            begin
                hard_mirroring_reg <= pwdata[0];
            end
        end
    end

    // mapper state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_banks_reg  <= '0;
            nametable_regs_reg <= '0;
            prg_banks_reg      <= '0;
            pattern_mode_reg   <= 2'd0;
            ram_on_reg         <= 1'b1;
            irq_count_reg      <= 16'd0;
            irq_on_reg         <= 1'b0;
            irq_ack_reg        <= 1'b0;
            irq_level_reg      <= 1'b0;
            mirror_mode_reg    <= cbm_pkg::MIR_VERTICAL;
        end
        else if (s1_fire || cfg_write)
        begin
            pattern_banks_reg  <= pattern_banks_next;
            nametable_regs_reg <= nametable_regs_next;
            prg_banks_reg      <= prg_banks_next;
            pattern_mode_reg   <= pattern_mode_next;
            ram_on_reg         <= ram_on_next;
            irq_count_reg      <= irq_count_next;
            irq_on_reg         <= irq_on_next;
            irq_ack_reg        <= irq_ack_next;
            irq_level_reg      <= irq_level_next;
            mirror_mode_reg    <= mirror_mode_next;
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            s1_action_reg  <= action;
            s1_address_reg <= address;
            s1_data_reg    <= data;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            read_data_reg  <= read_data_next;
            read_hit_reg   <= read_hit_next;
            irq_line_reg   <= irq_level_next;
            map_kind_reg   <= res_map_next.kind;
            map_bank_reg   <= res_map_next.bank;
            map_offset_reg <= res_map_next.offset;
        end
    end

    assign read_data  = read_data_reg;
    assign read_hit   = read_hit_reg;
    assign irq_line   = irq_line_reg;
    assign map_kind   = map_kind_reg;
    assign map_bank   = map_bank_reg;
    assign map_offset = map_offset_reg;

endmodule
